// File: design/ebml_hdr_pkg.sv
// Package for the EBML element header parser: widths, codes, word types
// and the VINT length function. No dependencies.
`default_nettype none

package ebml_hdr_pkg;

    localparam int OFFSET_WIDTH_DEF = 48;
    localparam int ID_W             = 29;
    localparam int SIZE_W           = 56;
    localparam int HLEN_W           = 4;
    localparam int POFF_W           = 48;
    localparam int LEN_W            = 4;
    localparam int ID_MAX_LEN       = 4;
    localparam logic [7:0] BYTE_ONES = 8'hFF;

    typedef enum logic [1:0] {
        PH_ID_FIRST   = 2'd0,
        PH_ID_REST    = 2'd1,
        PH_SIZE_FIRST = 2'd2,
        PH_SIZE_REST  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_ID   = 2'd1,
        ST_BAD_SIZE = 2'd2,
        ST_TRUNC    = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
        logic       new_stream;
    } t_in_word;

    typedef struct packed {
        logic [ID_W-1:0]   element_id;
        logic [SIZE_W-1:0] element_size;
        logic              size_unknown;
        logic [HLEN_W-1:0] header_length;
        logic [POFF_W-1:0] payload_offset;
        t_status           status;
    } t_out_word;

    // VINT length from the leading zeros of the first byte: 1 to 8, or 0
    // for a zero byte. The highest set bit wins.
    function automatic logic [LEN_W-1:0] lead_length(input logic [7:0] b);
        logic [LEN_W-1:0] len;
        len = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                len = LEN_W'(8 - i);
            end
        end
        return len;
    endfunction

endpackage

`default_nettype wire

// File: design/ebml_hdr_if.sv
// Handshake interfaces for the header parser's input and result channels.
// Depends on ebml_hdr_pkg for the field widths.
`default_nettype none

interface ebml_hdr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_end;
    logic       new_stream;

    modport source (output valid, data_byte, stream_end, new_stream, input ready);
    modport sink   (input valid, data_byte, stream_end, new_stream, output ready);
endinterface

interface ebml_hdr_out_if
    import ebml_hdr_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   element_id;
    logic [SIZE_W-1:0] element_size;
    logic              size_unknown;
    logic [HLEN_W-1:0] header_length;
    logic [POFF_W-1:0] payload_offset;
    logic [1:0]        status;

    modport source (output valid, element_id, element_size, size_unknown,
                    header_length, payload_offset, status, input ready);
    modport sink   (input valid, element_id, element_size, size_unknown,
                    header_length, payload_offset, status, output ready);
endinterface

`default_nettype wire

// File: design/ebml_hdr_core.sv
// Parser state and per-byte decode: one byte per step, at most one result.
// Depends on ebml_hdr_pkg.
`default_nettype none

module ebml_hdr_core
    import ebml_hdr_pkg::*;
#(
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_step,
    input  wire t_in_word  i_word,
    output logic           o_res_valid,
    output t_out_word      o_res
);

    t_phase                  r_phase, n_phase;
    logic [ID_W-1:0]         r_id_accum, n_id_accum;
    logic [SIZE_W-1:0]       r_size_accum, n_size_accum;
    logic [2:0]              r_bytes_left, n_bytes_left;
    logic [2:0]              r_id_len, n_id_len;
    logic [LEN_W-1:0]        r_size_len, n_size_len;
    logic                    r_all_ones, n_all_ones;
    logic [OFFSET_WIDTH-1:0] r_byte_offset, n_byte_offset;
    logic [OFFSET_WIDTH-1:0] r_header_start, n_header_start;

    logic [OFFSET_WIDTH-1:0] w_off;
    logic [POFF_W-1:0]       w_poff_next, w_poff_start;
    t_phase                  w_phase;
    logic [LEN_W-1:0]        w_len;
    logic [7:0]              w_mask;
    logic [7:0]              w_data;
    logic                    w_done;
    logic                    w_err;
    t_status                 w_err_code;

    assign w_off   = i_word.new_stream ? '0 : r_byte_offset;
    assign w_phase = i_word.new_stream ? PH_ID_FIRST : r_phase;
    assign w_len   = lead_length(i_word.data_byte);
    assign w_mask  = BYTE_ONES >> w_len;
    assign w_data  = i_word.data_byte & w_mask;
    assign n_byte_offset = w_off + OFFSET_WIDTH'(1);

    // Result offset field is fixed; wider counters cut, narrower zero-extended.
    generate
        if (OFFSET_WIDTH >= POFF_W) begin : g_off_cut
            assign w_poff_next  = n_byte_offset[POFF_W-1:0];
            assign w_poff_start = n_header_start[POFF_W-1:0];
        end else begin : g_off_ext
            assign w_poff_next  = {{(POFF_W-OFFSET_WIDTH){1'b0}}, n_byte_offset};
            assign w_poff_start = {{(POFF_W-OFFSET_WIDTH){1'b0}}, n_header_start};
        end
    endgenerate

    always_comb begin
        n_phase        = w_phase;
        n_id_accum     = r_id_accum;
        n_size_accum   = r_size_accum;
        n_bytes_left   = r_bytes_left;
        n_id_len       = r_id_len;
        n_size_len     = r_size_len;
        n_all_ones     = r_all_ones;
        n_header_start = r_header_start;
        w_done         = 1'b0;
        w_err          = 1'b0;
        w_err_code     = ST_OK;

        case (w_phase)
            PH_ID_FIRST: begin
                n_header_start = w_off;
                if (w_len == '0 || w_len > LEN_W'(ID_MAX_LEN)) begin
                    w_err      = 1'b1;
                    w_err_code = ST_BAD_ID;
                    n_phase    = PH_ID_FIRST;
                end else begin
                    n_id_accum   = ID_W'(i_word.data_byte);
                    n_id_len     = w_len[2:0];
                    n_bytes_left = 3'(w_len - LEN_W'(1));
                    n_phase      = (w_len == LEN_W'(1)) ? PH_SIZE_FIRST : PH_ID_REST;
                end
            end
            PH_ID_REST: begin
                n_id_accum   = {r_id_accum[ID_W-9:0], i_word.data_byte};
                n_bytes_left = r_bytes_left - 3'd1;
                if (n_bytes_left == 3'd0) begin
                    n_phase = PH_SIZE_FIRST;
                end
            end
            PH_SIZE_FIRST: begin
                if (w_len == '0) begin
                    w_err      = 1'b1;
                    w_err_code = ST_BAD_SIZE;
                    n_phase    = PH_ID_FIRST;
                end else begin
                    n_size_len   = w_len;
                    n_size_accum = SIZE_W'(w_data);
                    n_all_ones   = (w_data == w_mask);
                    n_bytes_left = 3'(w_len - LEN_W'(1));
                    if (w_len == LEN_W'(1)) begin
                        w_done = 1'b1;
                    end else begin
                        n_phase = PH_SIZE_REST;
                    end
                end
            end
            default: begin
                n_size_accum = {r_size_accum[SIZE_W-9:0], i_word.data_byte};
                n_all_ones   = r_all_ones && (i_word.data_byte == BYTE_ONES);
                n_bytes_left = r_bytes_left - 3'd1;
                if (n_bytes_left == 3'd0) begin
                    w_done = 1'b1;
                end
            end
        endcase

        // A header left unfinished by the last byte of the stream is cut short.
        if (w_done) begin
            n_phase = PH_ID_FIRST;
        end else if (!w_err && i_word.stream_end && n_phase != PH_ID_FIRST) begin
            w_err      = 1'b1;
            w_err_code = ST_TRUNC;
            n_phase    = PH_ID_FIRST;
        end
    end

    always_comb begin
        o_res_valid = w_done || w_err;
        if (w_done) begin
            o_res.element_id     = n_id_accum;
            o_res.element_size   = n_all_ones ? '0 : n_size_accum;
            o_res.size_unknown   = n_all_ones;
            o_res.header_length  = HLEN_W'({1'b0, n_id_len}) + HLEN_W'(n_size_len);
            o_res.payload_offset = w_poff_next;
            o_res.status         = ST_OK;
        end else begin
            o_res.element_id     = '0;
            o_res.element_size   = '0;
            o_res.size_unknown   = 1'b0;
            o_res.header_length  = '0;
            o_res.payload_offset = w_poff_start;
            o_res.status         = w_err_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_ID_FIRST;
            r_id_accum     <= '0;
            r_size_accum   <= '0;
            r_bytes_left   <= '0;
            r_id_len       <= '0;
            r_size_len     <= '0;
            r_all_ones     <= 1'b0;
            r_byte_offset  <= '0;
            r_header_start <= '0;
        end else if (i_step) begin
            r_phase        <= n_phase;
            r_id_accum     <= n_id_accum;
            r_size_accum   <= n_size_accum;
            r_bytes_left   <= n_bytes_left;
            r_id_len       <= n_id_len;
            r_size_len     <= n_size_len;
            r_all_ones     <= n_all_ones;
            r_byte_offset  <= n_byte_offset;
            r_header_start <= n_header_start;
        end
    end

endmodule

`default_nettype wire

// File: design/ebml_hdr_parser_top.sv
// EBML element header parser: takes one byte per word and returns one word per
// complete header or error. Each byte passes an input register, the parse
// logic and a result register, and a new byte is taken every cycle while the
// result side drains; the combinational decode of one byte against the
// registered parser state sets that rate. The offset counter is OFFSET_WIDTH
// bits and wraps; results carry its low 48 bits, zero-extended when narrower.
// No start-up sweep is needed after reset.
// Depends on ebml_hdr_pkg, ebml_hdr_if and ebml_hdr_core.
`default_nettype none

module ebml_element_header_parser_top
    import ebml_hdr_pkg::*;
#(
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    ebml_hdr_in_if.sink    i_in,
    ebml_hdr_out_if.source o_out
);

    logic      r_s1_valid;
    t_in_word  r_s1_word;
    logic      r_out_valid;
    t_out_word r_out_word;

    logic      w_advance;
    logic      w_step;
    logic      w_res_valid;
    t_out_word w_res;

    assign w_advance = !r_out_valid || o_out.ready;
    assign w_step    = r_s1_valid && w_advance;
    assign i_in.ready = !r_s1_valid || w_advance;

    ebml_hdr_core #(
        .OFFSET_WIDTH(OFFSET_WIDTH)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_step),
        .i_word     (r_s1_word),
        .o_res_valid(w_res_valid),
        .o_res      (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_word.data_byte  <= i_in.data_byte;
            r_s1_word.stream_end <= i_in.stream_end;
            r_s1_word.new_stream <= i_in.new_stream;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_step && w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_word <= w_res;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.element_id     = r_out_word.element_id;
    assign o_out.element_size   = r_out_word.element_size;
    assign o_out.size_unknown   = r_out_word.size_unknown;
    assign o_out.header_length  = r_out_word.header_length;
    assign o_out.payload_offset = r_out_word.payload_offset;
    assign o_out.status         = r_out_word.status;

endmodule

`default_nettype wire
